// File: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types, codes and byte classifiers for the decimal string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

  // Width of the internal accumulator (range 8 to 64).
  localparam int VALUE_BITS = 32;

  localparam int CHAR_BITS   = 8;
  localparam int STATUS_BITS = 2;
  localparam int OUT_BITS    = 32;
  localparam int TDATA_BITS  = 40;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_REJECT = 3'd4
  } phase_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_NAN      = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  // Registered input byte handed to the parser.
  typedef struct packed {
    logic                 valid;
    logic [CHAR_BITS-1:0] code;
  } char_word_t;

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// File: rtl/dsv_in_reg.sv
// ----------------------------------------------------------------------------
// dsv_in_reg
// Input register stage: captures one byte from the slave stream per cycle while s_tready is high.
// ----------------------------------------------------------------------------
module dsv_in_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dsv_pkg::CHAR_BITS-1:0]  s_tdata,
  input  logic                           advance,
  output dsv_pkg::char_word_t            char_word
);

  logic                          valid;
  logic [dsv_pkg::CHAR_BITS-1:0] code;

  // The register frees up when empty or when the parser consumes it now.
  assign s_tready  = !valid || advance;
  assign char_word = '{valid: valid, code: code};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      code <= s_tdata;
    end
  end

endmodule

// File: rtl/dsv_parser.sv
// ----------------------------------------------------------------------------
// dsv_parser
// Parse state, exact-overflow accumulator and the result register.
// ----------------------------------------------------------------------------
module dsv_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  dsv_pkg::char_word_t             char_word,
  output logic                            advance,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dsv_pkg::TDATA_BITS-1:0]  m_tdata
);

  localparam int VB = dsv_pkg::VALUE_BITS;

  dsv_pkg::phase_t  phase, phase_next;
  logic [VB-1:0]    acc, acc_next;
  logic             ovf, ovf_next;

  logic                          out_valid;
  dsv_pkg::status_t              out_status;
  logic [dsv_pkg::OUT_BITS-1:0]  out_value;
  dsv_pkg::status_t              status_calc;
  logic [VB-1:0]                 value_calc;

  logic          term, digit, space, plus;
  logic [VB+3:0] acc_x10;
  logic          digit_ovf;
  logic [VB-1:0] acc_digit;
  logic          out_free;

  assign term  = (char_word.code == dsv_pkg::CHAR_NUL);
  assign digit = dsv_pkg::is_digit(char_word.code);
  assign space = dsv_pkg::is_space(char_word.code);
  assign plus  = (char_word.code == dsv_pkg::CHAR_PLUS);

  // A terminator needs a free result register; other bytes always pass.
  assign out_free = !out_valid || m_tready;
  assign advance  = char_word.valid && (!term || out_free);

  // acc*10 + digit in a word four bits wider; any upper bit set is overflow.
  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                 + (VB+4)'(char_word.code - dsv_pkg::CHAR_ZERO);
  assign digit_ovf = |acc_x10[VB+3:VB];

  always_comb begin
    if (ovf) begin
      acc_digit = acc;
    end else if (digit_ovf) begin
      acc_digit = '1;
    end else begin
      acc_digit = acc_x10[VB-1:0];
    end
  end

  // Next parse state.
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    if (term) begin
      phase_next = dsv_pkg::PH_LEAD;
      acc_next   = '0;
      ovf_next   = 1'b0;
    end else begin
      case (phase)
        dsv_pkg::PH_LEAD: begin
          if (space) begin
            phase_next = dsv_pkg::PH_LEAD;
          end else if (plus) begin
            phase_next = dsv_pkg::PH_SIGN;
          end else if (digit) begin
            phase_next = dsv_pkg::PH_DIGITS;
            acc_next   = acc_digit;
            ovf_next   = ovf || digit_ovf;
          end else begin
            phase_next = dsv_pkg::PH_REJECT;
          end
        end
        dsv_pkg::PH_SIGN, dsv_pkg::PH_DIGITS: begin
          if (digit) begin
            phase_next = dsv_pkg::PH_DIGITS;
            acc_next   = acc_digit;
            ovf_next   = ovf || digit_ovf;
          end else if (space && phase == dsv_pkg::PH_DIGITS) begin
            phase_next = dsv_pkg::PH_TRAIL;
          end else begin
            phase_next = dsv_pkg::PH_REJECT;
          end
        end
        dsv_pkg::PH_TRAIL: begin
          if (!space) begin
            phase_next = dsv_pkg::PH_REJECT;
          end
        end
        default: begin
          phase_next = dsv_pkg::PH_REJECT;
        end
      endcase
    end
  end

  // Result for a terminator, checks in priority order.
  always_comb begin
    if (phase != dsv_pkg::PH_DIGITS && phase != dsv_pkg::PH_TRAIL) begin
      status_calc = dsv_pkg::ST_NAN;
      value_calc  = '0;
    end else if (ovf) begin
      status_calc = dsv_pkg::ST_OVERFLOW;
      value_calc  = '1;
    end else if (acc == '0) begin
      status_calc = dsv_pkg::ST_ZERO;
      value_calc  = '0;
    end else begin
      status_calc = dsv_pkg::ST_OK;
      value_calc  = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dsv_pkg::PH_LEAD;
      acc   <= '0;
      ovf   <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      acc   <= acc_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && term) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term) begin
      out_status <= status_calc;
      out_value  <= dsv_pkg::OUT_BITS'(value_calc);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(dsv_pkg::TDATA_BITS - dsv_pkg::STATUS_BITS - dsv_pkg::OUT_BITS){1'b0}},
                     out_value, out_status};

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && term) |=> (phase == dsv_pkg::PH_LEAD && acc == '0 && !ovf))
    else $error("parse state not cleared after terminator");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (acc == '1))
    else $error("overflow seen but accumulator not saturated");

  a_ovf_phase: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (phase == dsv_pkg::PH_DIGITS || phase == dsv_pkg::PH_TRAIL
             || phase == dsv_pkg::PH_REJECT))
    else $error("overflow flag set before any digit");

  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == dsv_pkg::ST_NAN || out_status == dsv_pkg::ST_ZERO))
      |-> (out_value == '0))
    else $error("non-numeric or zero result with nonzero value");

  a_no_term_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !(advance && term))
    else $error("terminator consumed while result register is held");
`endif

endmodule

// File: rtl/decimal_string_validator_top.sv
// ----------------------------------------------------------------------------
// decimal_string_validator_top
// Parses zero-terminated ASCII decimal strings and reports status and value.
// ----------------------------------------------------------------------------
// Usage: bytes arrive one word at a time on the s_ stream; a zero byte ends a
// string. The accepted form is optional whitespace (space, codes 9 to 13),
// an optional '+', one or more digits, then optional whitespace. Only the
// terminator produces a result word on the m_ stream, carrying a status
// (ok, not a number, overflow, zero) and the 32-bit value.
// A terminator taken from the s_ stream goes through the input register, then
// the result register, and is then presented on m_tvalid. The throughput is
// one byte per cycle while no terminator waits. The digit update (acc*10 + d
// with an exact overflow check on a word four bits wider) is combinational.
// When the receiver stalls, ordinary bytes keep flowing; only a terminator
// waits in the input register until the held result has been taken, so
// s_tready falls then. Reset (rst, synchronous) empties both registers and
// returns the parser to expecting leading whitespace.
// ----------------------------------------------------------------------------
module decimal_string_validator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dsv_pkg::CHAR_BITS-1:0]   s_tdata,   // [7:0] char_code
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dsv_pkg::TDATA_BITS-1:0]  m_tdata    // [1:0] status, [33:2] value
);

  // Byte held in the input register, and the parser's consume strobe.
  dsv_pkg::char_word_t char_word;
  logic                advance;

  dsv_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .advance   (advance),
    .char_word (char_word)
  );

  dsv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .char_word (char_word),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
